// ----- rtl/bacre_pkg.sv -----
package bacre_pkg;

    localparam int LINES          = 64;
    localparam int WORDS_PER_LINE = 8;
    localparam int ADDR_BITS      = 32;
    localparam int DATA_BITS      = 64;
    localparam int BE_BITS        = DATA_BITS / 8;

    localparam int IDX_W  = $clog2(LINES);
    localparam int WORD_W = $clog2(WORDS_PER_LINE);
    localparam int OFS_W  = WORD_W + 3;
    localparam int TAG_W  = ADDR_BITS - OFS_W;
    localparam int MEM_W  = IDX_W + WORD_W;

    typedef enum logic [1:0] {
        REQ_READ  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_WB    = 2'd2,
        REQ_FILL  = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        KIND_READ  = 3'd0,
        KIND_ACK   = 3'd1,
        KIND_MEMRD = 3'd2,
        KIND_EVICT = 3'd3,
        KIND_RETRY = 3'd4
    } resp_kind_t;

    typedef enum logic [1:0] {
        BUSY_IDLE = 2'd0,
        BUSY_FILL = 2'd1,
        BUSY_RUN  = 2'd2
    } busy_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_HIT_RD,
        S_HIT_OUT,
        S_MISS_OUT,
        S_RETRY_OUT,
        S_VICTIM,
        S_EVICT_RD,
        S_EVICT_OUT,
        S_COPY,
        S_ANSWER_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic run_store;
        logic scan_start;
        logic scan_rd;
        logic scan_cmp;
        logic victim;
        logic evict_rd;
        logic evict_out;
        logic copy;
        logic answer_out;
        logic hit_rd;
        logic hit_out;
        logic miss_out;
        logic retry_out;
    } cmd_t;

    typedef struct packed {
        req_type_t req;
        busy_t     busy;
        logic      last;
        logic      match;
        logic      scan_last;
        logic      evict_needed;
        logic      word_last;
        logic      out_free;
    } sts_t;

endpackage

// ----- rtl/blocking_assoc_cache_random_evict.sv -----
// Blocking, fully associative, write-back cache of 64 lines of 8 words with
// random replacement. One item is worked on at a time and in_ready is high
// only between items. Each lookup walks the tag store one entry at a time,
// a registered read and then a compare per entry; a hit stops at the
// matching line, a miss searches all 64 lines and a line insert stops at its
// line or after all 64. Inserting a line then writes its 8 words one a cycle
// into the single-port line store; when the cache is full and the line is
// not present, a victim chosen by a 16-bit LFSR is first sent out as 8
// eviction words. A busy request gets a retry transfer with no tag walk, and
// run words that do not end a run are only stored in the run buffer. The
// valid map is cleared by reset, so no clearing pass is needed. Results
// leave through a single output register; a stalled output holds the block.
module blocking_assoc_cache_random_evict
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] req_addr,
    input  logic [63:0] word_data,
    input  logic [7:0]  byte_enable,
    input  logic [2:0]  word_pos,
    input  logic        run_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  resp_kind,
    output logic [31:0] resp_addr,
    output logic [63:0] resp_data,
    output logic [2:0]  resp_word,
    output logic        resp_last
);

    bacre_pkg::cmd_t cmd;
    bacre_pkg::sts_t sts;

    // sequence each item: decode, tag walk, evict, line copy, answer
    bacre_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold tags, line words, run buffer, pending miss and the output transfer
    bacre_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .req_addr    (req_addr),
        .word_data   (word_data),
        .byte_enable (byte_enable),
        .word_pos    (word_pos),
        .run_last    (run_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .resp_kind   (resp_kind),
        .resp_addr   (resp_addr),
        .resp_data   (resp_data),
        .resp_word   (resp_word),
        .resp_last   (resp_last)
    );

endmodule

// ----- rtl/bacre_ctrl.sv -----
module bacre_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  bacre_pkg::sts_t  sts,
    output bacre_pkg::cmd_t  cmd
);

    bacre_pkg::state_t state_reg;
    bacre_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bacre_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bacre_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bacre_pkg::S_DECODE;
                end
            end
            bacre_pkg::S_DECODE:
            begin
                case (sts.req)
                    bacre_pkg::REQ_READ, bacre_pkg::REQ_WRITE:
                    begin
                        state_next = (sts.busy != bacre_pkg::BUSY_IDLE) ?
                                     bacre_pkg::S_RETRY_OUT : bacre_pkg::S_SCAN_RD;
                    end
                    bacre_pkg::REQ_WB:
                    begin
                        if (sts.busy == bacre_pkg::BUSY_FILL)
                        begin
                            state_next = bacre_pkg::S_RETRY_OUT;
                        end
                        else
                        begin
                            state_next = sts.last ? bacre_pkg::S_SCAN_RD : bacre_pkg::S_IDLE;
                        end
                    end
                    default:
                    begin
                        if (sts.busy == bacre_pkg::BUSY_FILL && sts.last)
                        begin
                            state_next = bacre_pkg::S_SCAN_RD;
                        end
                        else
                        begin
                            state_next = bacre_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            bacre_pkg::S_SCAN_RD:
            begin
                state_next = bacre_pkg::S_SCAN_CMP;
            end
            bacre_pkg::S_SCAN_CMP:
            begin
                if (sts.req == bacre_pkg::REQ_READ || sts.req == bacre_pkg::REQ_WRITE)
                begin
                    if (sts.match)
                    begin
                        state_next = bacre_pkg::S_HIT_RD;
                    end
                    else if (sts.scan_last)
                    begin
                        state_next = bacre_pkg::S_MISS_OUT;
                    end
                    else
                    begin
                        state_next = bacre_pkg::S_SCAN_RD;
                    end
                end
                else
                begin
                    state_next = (sts.match || sts.scan_last) ?
                                 bacre_pkg::S_VICTIM : bacre_pkg::S_SCAN_RD;
                end
            end
            bacre_pkg::S_HIT_RD:
            begin
                state_next = bacre_pkg::S_HIT_OUT;
            end
            bacre_pkg::S_HIT_OUT, bacre_pkg::S_MISS_OUT, bacre_pkg::S_RETRY_OUT,
            bacre_pkg::S_ANSWER_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = bacre_pkg::S_IDLE;
                end
            end
            bacre_pkg::S_VICTIM:
            begin
                state_next = sts.evict_needed ? bacre_pkg::S_EVICT_RD : bacre_pkg::S_COPY;
            end
            bacre_pkg::S_EVICT_RD:
            begin
                state_next = bacre_pkg::S_EVICT_OUT;
            end
            bacre_pkg::S_EVICT_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.word_last ? bacre_pkg::S_COPY : bacre_pkg::S_EVICT_RD;
                end
            end
            bacre_pkg::S_COPY:
            begin
                if (sts.word_last)
                begin
                    state_next = (sts.req == bacre_pkg::REQ_FILL) ?
                                 bacre_pkg::S_ANSWER_OUT : bacre_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bacre_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            bacre_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            bacre_pkg::S_DECODE:
            begin
                cmd.scan_start = 1'b1;
                if (sts.req == bacre_pkg::REQ_WB)
                begin
                    cmd.run_store = (sts.busy != bacre_pkg::BUSY_FILL);
                end
                else if (sts.req == bacre_pkg::REQ_FILL)
                begin
                    cmd.run_store = (sts.busy == bacre_pkg::BUSY_FILL);
                end
            end
            bacre_pkg::S_SCAN_RD:    cmd.scan_rd = 1'b1;
            bacre_pkg::S_SCAN_CMP:   cmd.scan_cmp = 1'b1;
            bacre_pkg::S_HIT_RD:     cmd.hit_rd = 1'b1;
            bacre_pkg::S_HIT_OUT:    cmd.hit_out = sts.out_free;
            bacre_pkg::S_MISS_OUT:   cmd.miss_out = sts.out_free;
            bacre_pkg::S_RETRY_OUT:  cmd.retry_out = sts.out_free;
            bacre_pkg::S_ANSWER_OUT: cmd.answer_out = sts.out_free;
            bacre_pkg::S_VICTIM:     cmd.victim = 1'b1;
            bacre_pkg::S_EVICT_RD:   cmd.evict_rd = 1'b1;
            bacre_pkg::S_EVICT_OUT:  cmd.evict_out = sts.out_free;
            bacre_pkg::S_COPY:       cmd.copy = 1'b1;
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/bacre_dp.sv -----
module bacre_dp
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  bacre_pkg::cmd_t                     cmd,
    output bacre_pkg::sts_t                     sts,
    input  logic [1:0]                          req_type,
    input  logic [bacre_pkg::ADDR_BITS-1:0]     req_addr,
    input  logic [bacre_pkg::DATA_BITS-1:0]     word_data,
    input  logic [bacre_pkg::BE_BITS-1:0]       byte_enable,
    input  logic [2:0]                          word_pos,
    input  logic                                run_last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          resp_kind,
    output logic [bacre_pkg::ADDR_BITS-1:0]     resp_addr,
    output logic [bacre_pkg::DATA_BITS-1:0]     resp_data,
    output logic [2:0]                          resp_word,
    output logic                                resp_last
);

    localparam int IDX_W  = bacre_pkg::IDX_W;
    localparam int WORD_W = bacre_pkg::WORD_W;
    localparam int OFS_W  = bacre_pkg::OFS_W;
    localparam int TAG_W  = bacre_pkg::TAG_W;
    localparam int AW     = bacre_pkg::ADDR_BITS;
    localparam int DW     = bacre_pkg::DATA_BITS;
    localparam int BW     = bacre_pkg::BE_BITS;

    function automatic logic [DW-1:0] merge_bytes(input logic [DW-1:0] old_w,
                                                  input logic [DW-1:0] new_w,
                                                  input logic [BW-1:0] be);
        logic [DW-1:0] res;
        res = old_w;
        for (int b = 0; b < BW; b++)
        begin
            if (be[b])
            begin
                res[8*b +: 8] = new_w[8*b +: 8];
            end
        end
        return res;
    endfunction

    // request held for the whole item
    bacre_pkg::req_type_t type_reg;
    logic [AW-1:0]        addr_reg;
    logic [DW-1:0]        data_reg;
    logic [BW-1:0]        be_reg;
    logic [2:0]           pos_reg;
    logic                 last_reg;

    bacre_pkg::busy_t     busy_reg;
    logic [AW-1:0]        pend_addr_reg;
    logic                 pend_write_reg;
    logic [DW-1:0]        pend_data_reg;
    logic [BW-1:0]        pend_mask_reg;
    logic [15:0]          lfsr_reg;
    logic [15:0]          lfsr_next;
    logic [bacre_pkg::LINES-1:0] valid_reg;

    logic [IDX_W-1:0]     scan_reg;
    logic                 hit_reg;
    logic [IDX_W-1:0]     hit_idx_reg;
    logic                 free_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic [IDX_W-1:0]     slot_reg;
    logic [WORD_W-1:0]    cnt_reg;
    logic [DW-1:0]        ans_reg;

    logic [DW-1:0]        run_buf [bacre_pkg::WORDS_PER_LINE];
    logic [TAG_W-1:0]     tag_mem [bacre_pkg::LINES];
    logic [DW-1:0]        line_mem [bacre_pkg::LINES * bacre_pkg::WORDS_PER_LINE];
    logic [TAG_W-1:0]     tag_rd_reg;
    logic [DW-1:0]        mem_rd_reg;

    logic                 out_valid_reg;
    logic [2:0]           kind_reg;
    logic [AW-1:0]        raddr_reg;
    logic [DW-1:0]        rdata_reg;
    logic [2:0]           rword_reg;
    logic                 rlast_reg;

    logic [TAG_W-1:0]     search_line;
    logic                 match;
    logic                 out_free;
    logic [WORD_W-1:0]    pend_word;
    logic [bacre_pkg::MEM_W-1:0] hit_addr;
    logic [bacre_pkg::MEM_W-1:0] slot_addr;
    logic [DW-1:0]        copy_word;
    logic                 evict_needed;

    logic                 out_load;
    logic [2:0]           kind_next;
    logic [AW-1:0]        raddr_next;
    logic [DW-1:0]        rdata_next;
    logic [2:0]           rword_next;
    logic                 rlast_next;

    assign search_line  = (type_reg == bacre_pkg::REQ_FILL) ? pend_addr_reg[AW-1:OFS_W]
                                                            : addr_reg[AW-1:OFS_W];
    assign match        = valid_reg[scan_reg] && (tag_rd_reg == search_line);
    assign out_free     = !out_valid_reg || out_ready;
    assign pend_word    = pend_addr_reg[OFS_W-1:3];
    assign hit_addr     = {hit_idx_reg, addr_reg[OFS_W-1:3]};
    assign slot_addr    = {slot_reg, cnt_reg};
    assign evict_needed = !hit_reg && !free_reg;
    assign lfsr_next    = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? 16'hB400 : 16'h0000);

    // fill merges the pending write into its word on the way in
    always_comb
    begin
        copy_word = run_buf[cnt_reg];
        if (type_reg == bacre_pkg::REQ_FILL && pend_write_reg && cnt_reg == pend_word)
        begin
            copy_word = merge_bytes(run_buf[cnt_reg], pend_data_reg, pend_mask_reg);
        end
    end

    always_comb
    begin
        sts.req          = type_reg;
        sts.busy         = busy_reg;
        sts.last         = last_reg;
        sts.match        = match;
        sts.scan_last    = (scan_reg == IDX_W'(bacre_pkg::LINES - 1));
        sts.evict_needed = evict_needed;
        sts.word_last    = (cnt_reg == WORD_W'(bacre_pkg::WORDS_PER_LINE - 1));
        sts.out_free     = out_free;
    end

    always_comb
    begin
        out_load   = 1'b1;
        kind_next  = bacre_pkg::KIND_RETRY;
        raddr_next = addr_reg;
        rdata_next = '0;
        rword_next = '0;
        rlast_next = 1'b1;
        if (cmd.retry_out)
        begin
            kind_next = bacre_pkg::KIND_RETRY;
        end
        else if (cmd.miss_out)
        begin
            kind_next  = bacre_pkg::KIND_MEMRD;
            raddr_next = {addr_reg[AW-1:OFS_W], OFS_W'(0)};
        end
        else if (cmd.hit_out)
        begin
            kind_next  = (type_reg == bacre_pkg::REQ_WRITE) ? bacre_pkg::KIND_ACK
                                                           : bacre_pkg::KIND_READ;
            rdata_next = (type_reg == bacre_pkg::REQ_WRITE) ? '0 : mem_rd_reg;
        end
        else if (cmd.evict_out)
        begin
            kind_next  = bacre_pkg::KIND_EVICT;
            raddr_next = {tag_rd_reg, OFS_W'(0)};
            rdata_next = mem_rd_reg;
            rword_next = 3'(cnt_reg);
            rlast_next = sts.word_last && (type_reg != bacre_pkg::REQ_FILL);
        end
        else if (cmd.answer_out)
        begin
            kind_next  = pend_write_reg ? bacre_pkg::KIND_ACK : bacre_pkg::KIND_READ;
            raddr_next = pend_addr_reg;
            rdata_next = pend_write_reg ? '0 : ans_reg;
        end
        else
        begin
            out_load = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= bacre_pkg::BUSY_IDLE;
            pend_addr_reg  <= '0;
            pend_write_reg <= 1'b0;
            pend_data_reg  <= '0;
            pend_mask_reg  <= '0;
            lfsr_reg       <= 16'hFFFF;
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.run_store && type_reg == bacre_pkg::REQ_WB && !last_reg)
            begin
                busy_reg <= bacre_pkg::BUSY_RUN;
            end
            if (cmd.miss_out)
            begin
                busy_reg       <= bacre_pkg::BUSY_FILL;
                pend_addr_reg  <= addr_reg;
                pend_write_reg <= (type_reg == bacre_pkg::REQ_WRITE);
                pend_data_reg  <= data_reg;
                pend_mask_reg  <= be_reg;
            end
            if (cmd.copy && sts.word_last)
            begin
                busy_reg <= bacre_pkg::BUSY_IDLE;
            end
            if (cmd.victim && !hit_reg)
            begin
                if (free_reg)
                begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
                else
                begin
                    lfsr_reg <= lfsr_next;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg <= bacre_pkg::req_type_t'(req_type);
            addr_reg <= req_addr;
            data_reg <= word_data;
            be_reg   <= byte_enable;
            pos_reg  <= word_pos;
            last_reg <= run_last;
        end
        if (cmd.run_store && 32'(pos_reg) < bacre_pkg::WORDS_PER_LINE)
        begin
            run_buf[pos_reg[WORD_W-1:0]] <= data_reg;
        end
        if (cmd.scan_start)
        begin
            scan_reg <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        if (cmd.scan_cmp)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= scan_reg;
            end
            if (!valid_reg[scan_reg] && !free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= scan_reg;
            end
        end
        if (cmd.victim)
        begin
            cnt_reg  <= '0;
            slot_reg <= hit_reg ? hit_idx_reg :
                        free_reg ? free_idx_reg : lfsr_next[IDX_W-1:0];
        end
        if (cmd.evict_out || cmd.copy)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.copy && cnt_reg == pend_word)
        begin
            ans_reg <= run_buf[cnt_reg];
        end
        if (out_load)
        begin
            kind_reg  <= kind_next;
            raddr_reg <= raddr_next;
            rdata_reg <= rdata_next;
            rword_reg <= rword_next;
            rlast_reg <= rlast_next;
        end
    end

    // tag store
    always_ff @(posedge clk)
    begin
        if (cmd.scan_rd)
        begin
            tag_rd_reg <= tag_mem[scan_reg];
        end
        else if (cmd.evict_rd)
        begin
            tag_rd_reg <= tag_mem[slot_reg];
        end
        if (cmd.copy && sts.word_last)
        begin
            tag_mem[slot_reg] <= search_line;
        end
    end

    // line data store
    always_ff @(posedge clk)
    begin
        if (cmd.hit_rd)
        begin
            mem_rd_reg <= line_mem[hit_addr];
        end
        else if (cmd.evict_rd)
        begin
            mem_rd_reg <= line_mem[slot_addr];
        end
        if (cmd.hit_out && type_reg == bacre_pkg::REQ_WRITE)
        begin
            line_mem[hit_addr] <= merge_bytes(mem_rd_reg, data_reg, be_reg);
        end
        else if (cmd.copy)
        begin
            line_mem[slot_addr] <= copy_word;
        end
    end

    assign out_valid = out_valid_reg;
    assign resp_kind = kind_reg;
    assign resp_addr = raddr_reg;
    assign resp_data = rdata_reg;
    assign resp_word = rword_reg;
    assign resp_last = rlast_reg;

endmodule
